FILE: rtl/core/ucp_pkg.sv
// ----------------------------------------------------------------------------
// ucp_pkg
// Shared types, widths and constants for the motor command to pwm block.
// ----------------------------------------------------------------------------
`default_nettype none

package ucp_pkg;

    localparam int FIELD_CHARS_DEFAULT = 4;

    // field and register widths
    localparam int BYTE_W     = 8;
    localparam int CMD_W      = 11;
    localparam int ACC_W      = 10;
    localparam int PERIOD_W   = 16;
    localparam int BASE_W     = 17;
    localparam int STEP_W     = 7;
    localparam int CMP_W      = 17;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_ADDR_W = 2;
    localparam int TDATA_IN_W = 8;
    localparam int TDATA_OUT_W = 56;

    // datapath widths
    localparam int DUTY_W  = 19;
    localparam int PROD_W  = PERIOD_W + BASE_W;
    localparam int QUOT_W  = 16;

    // divide by 100000 as a shift by 5 and a multiply by the reciprocal of 3125
    localparam int SCALE_SHIFT = 5;
    localparam int RECIP_W     = 29;
    localparam int RECIP_SHIFT = 40;
    localparam int DIV_IN_W    = PROD_W - SCALE_SHIFT;
    localparam int DIV_MUL_W   = DIV_IN_W + RECIP_W;
    localparam logic [RECIP_W-1:0] DIV3125_RECIP = 29'd351843721;

    localparam logic [DUTY_W-1:0] DUTY_SCALE = 19'd100000;
    localparam logic [ACC_W-1:0]  ACC_LIMIT  = 10'd999;

    localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_ONE   = 8'h31;
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET     = 16'd9375;
    localparam logic [BASE_W-1:0]   DRIVE_BASE_RESET = 17'd7025;
    localparam logic [BASE_W-1:0]   SERVO_BASE_RESET = 17'd7500;
    localparam logic [STEP_W-1:0]   STEP_RESET       = 7'd25;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PERIOD     = 2'd0,
        REG_DRIVE_BASE = 2'd1,
        REG_SERVO_BASE = 2'd2,
        REG_DUTY_STEP  = 2'd3
    } cfg_reg_t;

    typedef logic signed [CMD_W-1:0] cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t drive;
        cmd_t servo;
    } cmd_pair_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [BASE_W-1:0]   drive_base;
        logic [BASE_W-1:0]   servo_base;
        logic [STEP_W-1:0]   step;
    } pwm_cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/ucp_parser.sv
// ----------------------------------------------------------------------------
// ucp_parser
// Reads received characters as fixed sign/digit fields and pairs the drive
// and servo commands.
// ----------------------------------------------------------------------------
`default_nettype none

module ucp_parser
    import ucp_pkg::*;
#(
    parameter int FIELD_CHARS = FIELD_CHARS_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              byte_valid,
    input  wire logic [BYTE_W-1:0] rx_byte,
    output cmd_pair_t              pair
);

    localparam int POS_W = $clog2(FIELD_CHARS);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FIELD_CHARS - 1);
    localparam int SUM_W = ACC_W + 4;

    logic [POS_W-1:0] pos_reg,  pos_next;
    logic [ACC_W-1:0] acc_reg,  acc_next;
    logic             neg_reg,  neg_next;
    logic             sel_reg,  sel_next;
    cmd_t             held_reg, held_next;

    logic [3:0]       digit;
    logic [SUM_W-1:0] acc_ext;
    logic [SUM_W-1:0] acc_sum;
    logic [ACC_W-1:0] acc_upd;
    logic             neg_upd;
    cmd_t             field_mag;
    cmd_t             field_value;
    logic             field_last;

    always_comb begin
        if (rx_byte >= CHAR_ONE && rx_byte <= CHAR_NINE) begin
            digit = 4'(rx_byte - CHAR_ZERO);
        end else begin
            digit = 4'd0;
        end
        acc_ext = SUM_W'(acc_reg);
        acc_sum = (acc_ext << 3) + (acc_ext << 1) + SUM_W'(digit);
        if (pos_reg == '0) begin
            acc_upd = '0;
            neg_upd = (rx_byte == CHAR_MINUS);
        end else begin
            acc_upd = (acc_sum > SUM_W'(ACC_LIMIT)) ? ACC_LIMIT : acc_sum[ACC_W-1:0];
            neg_upd = neg_reg;
        end
        field_mag   = $signed({1'b0, acc_upd});
        field_value = neg_upd ? -field_mag : field_mag;
        field_last  = (pos_reg == POS_LAST);
    end

    always_comb begin
        pos_next   = pos_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        sel_next   = sel_reg;
        held_next  = held_reg;
        pair.valid = 1'b0;
        pair.drive = held_reg;
        pair.servo = field_value;
        if (byte_valid) begin
            if (field_last) begin
                pos_next = '0;
                acc_next = '0;
                neg_next = 1'b0;
                if (!sel_reg) begin
                    held_next = field_value;
                    sel_next  = 1'b1;
                end else begin
                    sel_next   = 1'b0;
                    pair.valid = 1'b1;
                end
            end else begin
                pos_next = pos_reg + POS_W'(1);
                acc_next = acc_upd;
                neg_next = neg_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            acc_reg  <= '0;
            neg_reg  <= 1'b0;
            sel_reg  <= 1'b0;
            held_reg <= '0;
        end else begin
            pos_reg  <= pos_next;
            acc_reg  <= acc_next;
            neg_reg  <= neg_next;
            sel_reg  <= sel_next;
            held_reg <= held_next;
        end
    end

`ifndef SYNTHESIS
    // the field selector flips on every completed field
    a_sel_flips: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_valid && field_last |=> sel_reg != $past(sel_reg))
        else $error("field select did not flip at end of field");

    // a command pair only leaves after the drive field was held
    a_pair_after_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        pair.valid |-> sel_reg && byte_valid && field_last)
        else $error("command pair emitted without a held drive field");

    a_acc_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_reg <= ACC_LIMIT)
        else $error("digit accumulator above limit");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/ucp_pwm_calc.sv
// ----------------------------------------------------------------------------
// ucp_pwm_calc
// Five-register pipeline from a command pair to both pwm compare values,
// with a per-stage ready chain so bubbles collapse.
// ----------------------------------------------------------------------------
`default_nettype none

module ucp_pwm_calc
    import ucp_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cmd_pair_t        in_pair,
    output logic                  in_ready,
    input  wire pwm_cfg_t         cfg,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [CMP_W-1:0]      drive_compare,
    output logic [CMP_W-1:0]      servo_compare,
    output cmd_t                  drive_command,
    output cmd_t                  servo_command
);

    localparam int LANES  = 2;
    localparam int CMD_EXT  = DUTY_W - CMD_W;
    localparam int STEP_EXT = DUTY_W - STEP_W;
    localparam int BASE_EXT = DUTY_W - BASE_W;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    cmd_t                     cmd1_reg   [LANES];
    cmd_t                     cmd2_reg   [LANES];
    cmd_t                     cmd3_reg   [LANES];
    cmd_t                     cmd4_reg   [LANES];
    cmd_t                     cmd5_reg   [LANES];
    logic signed [DUTY_W-1:0] duty2_reg  [LANES];
    logic [PROD_W-1:0]        prod3_reg  [LANES];
    logic                     nonpos3_reg[LANES];
    logic                     big3_reg   [LANES];
    logic [QUOT_W-1:0]        q4_reg     [LANES];
    logic                     nonpos4_reg[LANES];
    logic                     big4_reg   [LANES];
    logic [CMP_W-1:0]         cmp5_reg   [LANES];

    // a stage loads when empty or when its content moves on this cycle
    assign en5      = !v5_reg || out_ready;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_pair.valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    for (genvar c = 0; c < LANES; c++) begin : g_lane
        logic [BASE_W-1:0]        base;
        cmd_t                     cmd_in;
        logic signed [DUTY_W-1:0] duty_next;
        logic                     nonpos_next;
        logic                     big_next;
        logic [PROD_W-1:0]        prod_next;
        logic [DIV_MUL_W-1:0]     div_mul;
        logic [QUOT_W-1:0]        q_next;
        logic [CMP_W-1:0]         cmp_next;

        assign base   = (c == 0) ? cfg.drive_base : cfg.servo_base;
        assign cmd_in = (c == 0) ? in_pair.drive : in_pair.servo;

        always_comb begin
            duty_next = $signed({{BASE_EXT{1'b0}}, base})
                      + $signed({{CMD_EXT{cmd1_reg[c][CMD_W-1]}}, cmd1_reg[c]})
                      * $signed({{STEP_EXT{1'b0}}, cfg.step});

            nonpos_next = duty2_reg[c][DUTY_W-1] || (duty2_reg[c] == '0);
            big_next    = !duty2_reg[c][DUTY_W-1]
                       && ($unsigned(duty2_reg[c]) >= DUTY_SCALE);
            // only used below full scale, where the duty fits the base width
            prod_next   = PROD_W'(cfg.period) * PROD_W'(duty2_reg[c][BASE_W-1:0]);

            div_mul = DIV_MUL_W'(prod3_reg[c][PROD_W-1:SCALE_SHIFT])
                    * DIV_MUL_W'(DIV3125_RECIP);
            q_next  = div_mul[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];

            if (nonpos4_reg[c]) begin
                cmp_next = '0;
            end else if (big4_reg[c] || q4_reg[c] >= cfg.period) begin
                cmp_next = CMP_W'(cfg.period) + CMP_W'(1);
            end else begin
                cmp_next = CMP_W'(q4_reg[c]);
            end
        end

        always_ff @(posedge aclk) begin
            if (en1) begin
                cmd1_reg[c] <= cmd_in;
            end
            if (en2) begin
                cmd2_reg[c]  <= cmd1_reg[c];
                duty2_reg[c] <= duty_next;
            end
            if (en3) begin
                cmd3_reg[c]    <= cmd2_reg[c];
                prod3_reg[c]   <= prod_next;
                nonpos3_reg[c] <= nonpos_next;
                big3_reg[c]    <= big_next;
            end
            if (en4) begin
                cmd4_reg[c]    <= cmd3_reg[c];
                q4_reg[c]      <= q_next;
                nonpos4_reg[c] <= nonpos3_reg[c];
                big4_reg[c]    <= big3_reg[c];
            end
            if (en5) begin
                cmd5_reg[c] <= cmd4_reg[c];
                cmp5_reg[c] <= cmp_next;
            end
        end
    end

    assign out_valid     = v5_reg;
    assign drive_compare = cmp5_reg[0];
    assign servo_compare = cmp5_reg[1];
    assign drive_command = cmd5_reg[0];
    assign servo_command = cmd5_reg[1];

`ifndef SYNTHESIS
    a_cmp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        v5_reg |-> (cmp5_reg[0] <= CMP_W'(cfg.period) + CMP_W'(1))
                && (cmp5_reg[1] <= CMP_W'(cfg.period) + CMP_W'(1)))
        else $error("compare value above period plus one");

    // duty cannot be both non-positive and at full scale
    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg |-> !(nonpos3_reg[0] && big3_reg[0]) && !(nonpos3_reg[1] && big3_reg[1]))
        else $error("duty flags both set");

    // a stalled quotient stage keeps its item
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg && !en5 |=> v4_reg && $stable(q4_reg[0]) && $stable(q4_reg[1]))
        else $error("quotient stage lost data while stalled");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/uart_motor_command_to_pwm.sv
// ----------------------------------------------------------------------------
// uart_motor_command_to_pwm
// Turns a received character stream of drive and servo commands into pwm
// compare values for both channels.
// ----------------------------------------------------------------------------
// One received byte is taken every clock cycle while s_tready is high. Bytes
// form fields of FIELD_CHARS characters: a sign position ('-' for negative)
// and decimal digits; the first field is the drive command, the second the
// servo command. The byte that completes the servo field passes the five
// pipeline registers, then gives one m_ transfer with both compare values
// and both commands. The compare path is a five-register pipeline (duty
// multiply, period multiply, reciprocal multiply for the divide by 100000,
// clamp), and a waiting result does not hold up input until that pipeline
// is full. The user must write configuration through the cfg_ port only
// while no command is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_motor_command_to_pwm
    import ucp_pkg::*;
#(
    parameter int FIELD_CHARS = FIELD_CHARS_DEFAULT
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // rx_byte
    input  wire logic [TDATA_IN_W-1:0]  s_tdata,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // drive_compare, servo_compare, drive_command, servo_command
    output logic [TDATA_OUT_W-1:0]      m_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    logic [PERIOD_W-1:0] period_reg;
    logic [BASE_W-1:0]   drive_base_reg;
    logic [BASE_W-1:0]   servo_base_reg;
    logic [STEP_W-1:0]   step_reg;

    pwm_cfg_t    cfg;
    cmd_pair_t   pair;
    logic        byte_xfer;
    logic [CMP_W-1:0] drive_compare;
    logic [CMP_W-1:0] servo_compare;
    cmd_t        drive_command;
    cmd_t        servo_command;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg     <= PERIOD_RESET;
            drive_base_reg <= DRIVE_BASE_RESET;
            servo_base_reg <= SERVO_BASE_RESET;
            step_reg       <= STEP_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_PERIOD:     period_reg     <= cfg_wdata[PERIOD_W-1:0];
                REG_DRIVE_BASE: drive_base_reg <= cfg_wdata[BASE_W-1:0];
                REG_SERVO_BASE: servo_base_reg <= cfg_wdata[BASE_W-1:0];
                REG_DUTY_STEP:  step_reg       <= cfg_wdata[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.period     = period_reg;
    assign cfg.drive_base = drive_base_reg;
    assign cfg.servo_base = servo_base_reg;
    assign cfg.step       = step_reg;

    assign byte_xfer = s_tvalid && s_tready;

    ucp_parser #(
        .FIELD_CHARS (FIELD_CHARS)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (byte_xfer),
        .rx_byte    (s_tdata[BYTE_W-1:0]),
        .pair       (pair)
    );

    ucp_pwm_calc u_calc (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_pair       (pair),
        .in_ready      (s_tready),
        .cfg           (cfg),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .drive_compare (drive_compare),
        .servo_compare (servo_compare),
        .drive_command (drive_command),
        .servo_command (servo_command)
    );

    assign m_tdata = {servo_command, drive_command, servo_compare, drive_compare};

endmodule

`default_nettype wire
